>>> hdl/ffsa_pkg.sv
// Package for the first-fit segment allocator: status codes, widths, FSM states.
// No dependencies.
package ffsa_pkg;

  localparam int MaxSegmentsDefault = 16;
  localparam int AddrBits           = 16;
  localparam int SizeWidth          = AddrBits + 1;
  localparam int StatusWidth        = 3;

  localparam logic [StatusWidth-1:0] StOk       = 3'd0;
  localparam logic [StatusWidth-1:0] StNoFit    = 3'd1;
  localparam logic [StatusWidth-1:0] StFull     = 3'd2;
  localparam logic [StatusWidth-1:0] StBadSize  = 3'd3;
  localparam logic [StatusWidth-1:0] StNotFound = 3'd4;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SPLIT,
    S_MARK,
    S_JOIN,
    S_MERGE_RD,
    S_MERGE_WR,
    S_DONE
  } ffsa_state_t;

endpackage

>>> hdl/ffsa_table.sv
// Segment table memory: one synchronous RAM holding start, length and free flag.
// Depends on ffsa_pkg for the address and size widths.
module ffsa_table
  import ffsa_pkg::*;
#(
  parameter int MAX_SEGMENTS = MaxSegmentsDefault,
  localparam int IdxW = $clog2(MAX_SEGMENTS),
  localparam int EntW = AddrBits + SizeWidth + 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [IdxW-1:0] waddr,
  input  logic [EntW-1:0] wdata,
  input  logic [IdxW-1:0] raddr,
  output logic [EntW-1:0] rdata
);

  logic [EntW-1:0] mem [MAX_SEGMENTS];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/first_fit_segment_allocator.sv
// First-fit segment allocator top level: request handshake, control sequencer, table.
// Depends on ffsa_pkg and ffsa_table.
//
// Channel  | Direction | Content
// s_axis   | in        | tdata: mode, request_size, free_address
// m_axis   | out       | tdata: granted_address, status
// cfg      | in        | memory_size write, reinitializes the table
//
// One request at a time. The scan reads the table entry by entry until a match or the
// last entry; a decision state and a done state follow, and the result is valid after that.
// A split adds a read and a write per entry moved up plus two writes; an exact fit
// adds one write. A free adds one merge write plus a read and a write per entry
// moved down. Reset and memory_size writes clear the table by an init pass over all
// MAX_SEGMENTS entries. The result register holds while m_axis_tready is low; no new
// request is taken.
module first_fit_segment_allocator
  import ffsa_pkg::*;
#(
  parameter int MAX_SEGMENTS = MaxSegmentsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,       // memory_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,    // [0] mode, [17:1] request_size, [33:18] free_address
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata     // [15:0] granted_address, [18:16] status
);

  localparam int IdxW = $clog2(MAX_SEGMENTS);
  localparam int CntW = $clog2(MAX_SEGMENTS + 1);
  localparam int EntW = AddrBits + SizeWidth + 1;
  localparam logic [SizeWidth:0] MemMax = (SizeWidth + 1)'(1) << AddrBits;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_SEGMENTS);

  // Entry layout: {free, length, start}.
  function automatic logic [EntW-1:0] pack_ent(logic f, logic [SizeWidth-1:0] l,
                                               logic [AddrBits-1:0] s);
    pack_ent = {f, l, s};
  endfunction

  ffsa_state_t state, state_next;

  logic [SizeWidth-1:0]   memory_size;
  logic [CntW-1:0]        count;
  logic [CntW-1:0]        idx;        // scan / init / shift / merge pointer
  logic [IdxW-1:0]        hit;        // found entry index
  logic                   req_mode;
  logic [SizeWidth-1:0]   req_size;
  logic [AddrBits-1:0]    req_addr;
  logic [AddrBits-1:0]    out_addr;
  logic [StatusWidth-1:0] out_status;
  logic                   out_valid;
  logic                   rd_pending;  // read data in this cycle belongs to idx-1
  logic [EntW-1:0]        hit_ent;     // copy of the found entry
  logic [EntW-1:0]        prev_ent;    // entry before the found one
  logic                   prev_valid;
  logic [1:0]             merge_step;  // number of entries dropped by a merge

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [EntW-1:0] wdata, rdata;

  ffsa_table #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_table (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic                 r_free;
  logic [SizeWidth-1:0] r_len;
  logic [AddrBits-1:0]  r_start;
  assign {r_free, r_len, r_start} = rdata;

  logic                 h_free;
  logic [SizeWidth-1:0] h_len;
  logic [AddrBits-1:0]  h_start;
  assign {h_free, h_len, h_start} = hit_ent;

  logic                 p_free;
  logic [SizeWidth-1:0] p_len;
  logic [AddrBits-1:0]  p_start;
  assign {p_free, p_len, p_start} = prev_ent;

  logic [CntW-1:0] hit_c;
  assign hit_c = CntW'(hit);

  // Requested input fields.
  logic                 in_mode;
  logic [SizeWidth-1:0] in_size;
  logic [AddrBits-1:0]  in_faddr;
  assign in_mode  = s_axis_tdata[0];
  assign in_size  = s_axis_tdata[17:1];
  assign in_faddr = s_axis_tdata[33:18];

  // Scan match on the entry read last cycle.
  logic scan_match;
  always_comb begin
    if (req_mode == ModeAlloc) begin
      scan_match = r_free && (r_len >= req_size);
    end else begin
      scan_match = (r_start == req_addr);
    end
  end

  // Clamped memory size.
  logic [SizeWidth:0] cfg_clamp;
  always_comb begin
    cfg_clamp = {1'b0, cfg_wdata};
    if (cfg_wdata == '0) cfg_clamp = (SizeWidth + 1)'(1);
    if (cfg_clamp > MemMax) cfg_clamp = MemMax;
  end

  // Merge plan for a free: the successor is on the read port, the predecessor was
  // kept during the scan. The merged entry lands at dest and later entries move down.
  logic                 succ_join;
  logic                 pred_join;
  logic [1:0]           join_cnt;
  logic [SizeWidth-1:0] join_len;
  logic [IdxW-1:0]      join_dst;
  logic [CntW-1:0]      join_src;
  always_comb begin
    succ_join = (hit_c + CntW'(1) < count) && r_free;
    pred_join = prev_valid && p_free;
    join_cnt  = {1'b0, succ_join} + {1'b0, pred_join};
    join_len  = h_len;
    if (succ_join) join_len = join_len + r_len;
    if (pred_join) join_len = join_len + p_len;
    join_dst  = pred_join ? (hit - IdxW'(1)) : hit;
    join_src  = hit_c + CntW'(1) + CntW'(succ_join);
  end

  assign s_axis_tready = (state == S_IDLE) && !out_valid && !cfg_we;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_status, out_addr};

  // Next state; a memory_size write restarts the table from any state.
  always_comb begin
    state_next = state;
    if (cfg_we) begin
      state_next = S_INIT;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            if (in_mode == ModeAlloc && in_size == '0) state_next = S_DONE;
            else state_next = S_SCAN;
          end
        end
        S_INIT: if (idx == CntW'(MAX_SEGMENTS - 1)) state_next = S_IDLE;
        S_SCAN: begin
          if (rd_pending && scan_match) state_next = S_DECIDE;
          else if (rd_pending && idx == count) state_next = S_DONE;
        end
        S_DECIDE: begin
          if (req_mode == ModeAlloc) begin
            if (h_len > req_size) begin
              if (count >= CntMax) state_next = S_DONE;
              else if (count > hit_c + CntW'(1)) state_next = S_SHIFT_RD;
              else state_next = S_SPLIT;
            end else begin
              state_next = S_MARK;
            end
          end else begin
            if (h_free) state_next = S_DONE;
            else state_next = S_JOIN;
          end
        end
        S_SHIFT_RD: state_next = S_SHIFT_WR;
        S_SHIFT_WR: begin
          if (idx == hit_c + CntW'(2)) state_next = S_SPLIT;
          else state_next = S_SHIFT_RD;
        end
        S_SPLIT: state_next = S_MARK;
        S_MARK: state_next = S_DONE;
        S_JOIN: begin
          if (join_cnt != 2'd0 && join_src < count) state_next = S_MERGE_RD;
          else state_next = S_DONE;
        end
        S_MERGE_RD: state_next = S_MERGE_WR;
        S_MERGE_WR: begin
          if (idx + CntW'(1) == count) state_next = S_DONE;
          else state_next = S_MERGE_RD;
        end
        S_DONE: state_next = S_IDLE;
        default: state_next = S_IDLE;
      endcase
    end
  end

  // Memory port control.
  // Shift up: idx walks from count down to hit+2, copying entry idx-1 to idx.
  // Merge: idx walks from the first entry after the merged span to count-1,
  // copying entry idx down by the number of dropped entries.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = idx[IdxW-1:0];
    case (state)
      S_INIT: begin
        we    = 1'b1;
        waddr = idx[IdxW-1:0];
        wdata = (idx == '0) ? pack_ent(1'b1, memory_size, '0) : '0;
      end
      S_DECIDE: raddr = IdxW'(hit_c + CntW'(1));
      S_SHIFT_RD: raddr = IdxW'(idx - CntW'(1));
      S_SHIFT_WR: begin
        we    = 1'b1;
        waddr = idx[IdxW-1:0];
        wdata = rdata;
      end
      S_SPLIT: begin
        we    = 1'b1;
        waddr = IdxW'(hit_c + CntW'(1));
        wdata = pack_ent(1'b1, h_len - req_size, h_start + req_size[AddrBits-1:0]);
      end
      S_MARK: begin
        we    = 1'b1;
        waddr = hit;
        wdata = pack_ent(1'b0, req_size, h_start);
      end
      S_JOIN: begin
        we    = 1'b1;
        waddr = join_dst;
        wdata = pack_ent(1'b1, join_len, pred_join ? p_start : h_start);
      end
      S_MERGE_WR: begin
        we    = 1'b1;
        waddr = IdxW'(idx - CntW'(merge_step));
        wdata = rdata;
      end
      default: ;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      memory_size <= MemMax[SizeWidth-1:0];
      count       <= CntW'(1);
      idx         <= '0;
      out_valid   <= 1'b0;
      rd_pending  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end else if (state == S_DONE && !cfg_we) begin
        out_valid <= 1'b1;
      end
      if (cfg_we) begin
        memory_size <= cfg_clamp[SizeWidth-1:0];
        count       <= CntW'(1);
        idx         <= '0;
      end else begin
        case (state)
          S_IDLE: begin
            if (s_axis_tvalid && s_axis_tready) begin
              req_mode   <= in_mode;
              req_size   <= in_size;
              req_addr   <= in_faddr;
              idx        <= '0;
              rd_pending <= 1'b0;
              prev_valid <= 1'b0;
              out_addr   <= '0;
              out_status <= StBadSize;
            end
          end
          S_INIT: idx <= idx + CntW'(1);
          S_SCAN: begin
            rd_pending <= 1'b1;
            if (rd_pending && scan_match) begin
              hit_ent <= rdata;
              hit     <= IdxW'(idx - CntW'(1));
            end else if (rd_pending && idx == count) begin
              out_status <= (req_mode == ModeAlloc) ? StNoFit : StNotFound;
            end else begin
              if (rd_pending) begin
                prev_ent   <= rdata;
                prev_valid <= 1'b1;
              end
              idx <= idx + CntW'(1);
            end
          end
          S_DECIDE: begin
            if (req_mode == ModeAlloc) begin
              if (h_len > req_size && count >= CntMax) begin
                out_status <= StFull;
              end else begin
                out_status <= StOk;
                out_addr   <= h_start;
                if (h_len > req_size) idx <= count;
              end
            end else if (h_free) begin
              out_status <= StNotFound;
            end else begin
              out_status <= StOk;
            end
          end
          S_SHIFT_WR: idx <= idx - CntW'(1);
          S_SPLIT: count <= count + CntW'(1);
          S_JOIN: begin
            merge_step <= join_cnt;
            idx        <= join_src;
            if (!(join_cnt != 2'd0 && join_src < count)) begin
              count <= count - CntW'(join_cnt);
            end
          end
          S_MERGE_WR: begin
            idx <= idx + CntW'(1);
            if (idx + CntW'(1) == count) count <= count - CntW'(merge_step);
          end
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (state == S_IDLE))
    else $error("request accepted while busy");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count >= CntW'(1)) && (count <= CntMax))
    else $error("segment count out of range");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_status <= StNotFound))
    else $error("bad status code");
`endif

endmodule

>>> tb/first_fit_segment_allocator_test.sv
// Self-checking testbench for first_fit_segment_allocator: drives allocate and free requests,
// predicts every result with its own copy of the segment table and checks them in order.
// Depends on ffsa_pkg and the first_fit_segment_allocator RTL.
module first_fit_segment_allocator_test;
  import ffsa_pkg::*;

  localparam int NumSegments = 16;
  localparam int IdleLimit   = 4000;
  localparam int DrainCycles = 100;

  typedef struct {
    logic [15:0]            addr;
    logic [StatusWidth-1:0] status;
  } grant_t;

  // Tracks the segment table and the queue of results still owed by the block.
  class alloc_scoreboard;
    logic [16:0] mem_size;
    logic [16:0] seg_start[NumSegments];
    logic [16:0] seg_len[NumSegments];
    bit          seg_free[NumSegments];
    int          seg_count;
    grant_t      owed[$];
    int          errors;

    function void set_memory_size(logic [16:0] v);
      mem_size = (v == 0) ? 17'd1 : (v > 17'd65536 ? 17'd65536 : v);
      for (int i = 0; i < NumSegments; i++) begin
        seg_start[i] = 0;
        seg_len[i] = 0;
        seg_free[i] = 0;
      end
      seg_len[0] = mem_size;
      seg_free[0] = 1;
      seg_count = 1;
    endfunction

    // Remove entry k, shifting the later entries down.
    function void drop_entry(int k);
      for (int i = k; i + 1 < seg_count; i++) begin
        seg_start[i] = seg_start[i+1];
        seg_len[i] = seg_len[i+1];
        seg_free[i] = seg_free[i+1];
      end
      seg_count--;
      seg_start[seg_count] = 0;
      seg_len[seg_count] = 0;
      seg_free[seg_count] = 0;
    endfunction

    function grant_t allocate(logic [16:0] req);
      grant_t g;
      int k;
      g.addr = 0;
      if (req == 0) begin
        g.status = StBadSize;
        return g;
      end
      for (k = 0; k < seg_count; k++)
        if (seg_free[k] && seg_len[k] >= req) break;
      if (k >= seg_count) begin
        g.status = StNoFit;
        return g;
      end
      if (seg_len[k] > req) begin
        if (seg_count >= NumSegments) begin
          g.status = StFull;
          return g;
        end
        for (int i = seg_count; i > k + 1; i--) begin
          seg_start[i] = seg_start[i-1];
          seg_len[i] = seg_len[i-1];
          seg_free[i] = seg_free[i-1];
        end
        seg_start[k+1] = seg_start[k] + req;
        seg_len[k+1] = seg_len[k] - req;
        seg_free[k+1] = 1;
        seg_len[k] = req;
        seg_count++;
      end
      seg_free[k] = 0;
      g.addr = seg_start[k][15:0];
      g.status = StOk;
      return g;
    endfunction

    function grant_t release_segment(logic [15:0] a);
      grant_t g;
      int k;
      g.addr = 0;
      for (k = 0; k < seg_count; k++)
        if (seg_start[k] == {1'b0, a}) break;
      if (k >= seg_count || seg_free[k]) begin
        g.status = StNotFound;
        return g;
      end
      seg_free[k] = 1;
      // Merge with a free successor first, then with a free predecessor.
      if (k + 1 < seg_count && seg_free[k+1]) begin
        seg_len[k] += seg_len[k+1];
        drop_entry(k + 1);
      end
      if (k > 0 && seg_free[k-1]) begin
        seg_len[k-1] += seg_len[k];
        drop_entry(k);
      end
      g.status = StOk;
      return g;
    endfunction

    function void note_request(logic [39:0] d);
      if (d[0] == ModeAlloc) owed.push_back(allocate(d[17:1]));
      else owed.push_back(release_segment(d[33:18]));
    endfunction

    function void check_result(logic [23:0] d);
      grant_t g;
      if (owed.size() == 0) begin
        $display("%0t: result %h arrived with nothing expected", $time, d);
        errors++;
        return;
      end
      g = owed.pop_front();
      if (d[15:0] !== g.addr) begin
        $display("%0t: granted_address expected %h, got %h", $time, g.addr, d[15:0]);
        errors++;
      end
      if (d[18:16] !== g.status) begin
        $display("%0t: status expected %0d, got %0d", $time, g.status, d[18:16]);
        errors++;
      end
    endfunction

    // Start of a random allocated segment, if there is one.
    function bit pick_busy(output logic [15:0] a);
      int busy[$];
      for (int i = 0; i < seg_count; i++)
        if (!seg_free[i]) busy.push_back(i);
      if (busy.size() == 0) return 0;
      a = seg_start[busy[$urandom_range(busy.size() - 1)]][15:0];
      return 1;
    endfunction

    // Length of a random free segment, or zero if none is free.
    function logic [16:0] pick_free_len();
      int idle[$];
      for (int i = 0; i < seg_count; i++)
        if (seg_free[i]) idle.push_back(i);
      if (idle.size() == 0) return 0;
      return seg_len[idle[$urandom_range(idle.size() - 1)]];
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [16:0] cfg_wdata = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = 0;  // [0] mode, [17:1] request_size, [33:18] free_address
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;      // [15:0] granted_address, [18:16] status

  alloc_scoreboard sb = new();
  bit  gaps_on = 1;
  int  idle_cycles = 0;

  first_fit_segment_allocator DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always #6 clk = ~clk;

  // Result side: check each accepted result.
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Result side back-pressure in random bursts.
  initial begin
    @(posedge clk);
    forever begin
      if (gaps_on && $urandom_range(2) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      m_axis_tready <= 1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: timeout, no handshake for %0d cycles", $time, IdleLimit);
      $display("** first_fit_segment_allocator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(bit mode, logic [16:0] req, logic [15:0] addr);
    if (gaps_on && $urandom_range(3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'd0, addr, req, mode};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request({6'd0, addr, req, mode});
  endtask

  task automatic alloc(logic [16:0] req);
    send_request(ModeAlloc, req, 16'($urandom()));
  endtask

  task automatic release_at(logic [15:0] a);
    send_request(ModeFree, 17'($urandom_range(17'h1ffff)), a);
  endtask

  // Let every owed result come back, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_memory_size(logic [16:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_memory_size(v);
  endtask

  // One random request, mostly well-formed against the current table.
  task automatic random_request();
    logic [15:0] a;
    logic [16:0] len;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      len = sb.mem_size >> $urandom_range(2, 8);
      alloc(17'($urandom_range(1, (len == 0) ? 1 : len)));
    end else if (pick < 55) begin
      len = sb.pick_free_len();
      alloc((len == 0) ? 17'd1 : len);
    end else if (pick < 85) begin
      if (sb.pick_busy(a)) release_at(a);
      else release_at(16'($urandom()));
    end else if (pick < 90) begin
      alloc(17'd0);
    end else if (pick < 95) begin
      alloc(17'($urandom_range(65536)));
    end else begin
      release_at(16'($urandom()));
    end
  endtask

  initial begin
    logic [16:0] sizes[6];
    sizes = '{17'd1, 17'd0, 17'h1ffff, 17'd37, 17'd1000, 17'd0};
    sizes[5] = 17'($urandom_range(1, 65536));
    sb.set_memory_size(17'd65536);
    repeat (3) @(posedge clk);
    rst <= 0;

    // Directed: bad size, exact fit of the whole memory, no fit, merges, full table.
    alloc(17'd0);
    alloc(17'd65536);
    alloc(17'd1);
    release_at(16'd0);
    release_at(16'd0);
    release_at(16'hffff);
    alloc(17'd100);
    alloc(17'd200);
    alloc(17'd300);
    release_at(16'd100);
    release_at(16'd0);
    release_at(16'd300);
    for (int i = 0; i < 15; i++) alloc(17'd1);
    alloc(17'd1);
    alloc(17'd65521);
    release_at(16'd7);
    drain();

    // Random phases over several memory sizes, extremes first.
    for (int p = 0; p < 6; p++) begin
      if (p == 5) gaps_on = 0;
      write_memory_size(sizes[p]);
      repeat (255) random_request();
      drain();
    end

    if (sb.errors == 0) begin
      $display("** first_fit_segment_allocator: PASSED **");
    end else begin
      $display("** first_fit_segment_allocator: FAILED **");
    end
    $finish;
  end
endmodule

>>> sim.f
hdl/ffsa_pkg.sv
hdl/ffsa_table.sv
hdl/first_fit_segment_allocator.sv
tb/first_fit_segment_allocator_test.sv
